// File: src/assert_macros.svh
// Assertion macros shared by the trie lookup RTL.
// Depends on nothing; included by modules that carry checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPL(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
  `ASSERT_IMPL(lbl, clk, rst_n, !(cond))
`else
`define ASSERT_IMPL(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

// File: src/bti_pkg.sv
// Types and codes for the binary trie lookup block.
// Depends on nothing.
package bti_pkg;
  localparam int KeyW = 32;

  typedef enum logic [1:0] {
    ST_FOUND    = 2'd0,
    ST_MISSING  = 2'd1,
    ST_INSERTED = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  typedef enum logic {
    CMD_SEARCH = 1'b0,
    CMD_INSERT = 1'b1
  } cmd_t;

  typedef struct packed {
    logic          command;
    logic [KeyW-1:0] key;
  } in_item_t;

  typedef struct packed {
    logic [1:0] status;
    logic [8:0] leaf_index;
  } out_item_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_READ,
    BK_WAIT,
    BK_STEP,
    BK_DIFF,
    BK_WRITE,
    BK_LINK,
    BK_DONE
  } back_state_t;
endpackage

// File: src/bti_front.sv
// Input side: takes items, masks keys and queues them for the walk engine.
// Depends on bti_pkg and assert_macros.svh.
`include "assert_macros.svh"
module bti_front #(
  parameter int KEY_BITS = 32,
  parameter int DEPTH = 2
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  bti_pkg::in_item_t   push_item,
  output logic                full,
  output logic                empty,
  input  logic                pop,
  output bti_pkg::in_item_t   head
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  bti_pkg::in_item_t q_r [DEPTH];
  logic [AW-1:0] wp_r, rp_r;
  logic [AW:0] cnt_r;
  bti_pkg::in_item_t masked;

  // Key bits above the configured width never take part in any compare.
  always_comb begin
    masked = push_item;
    if (KEY_BITS < bti_pkg::KeyW) begin
      for (int i = 0; i < bti_pkg::KeyW; i++) begin
        if (i >= KEY_BITS) masked.key[i] = 1'b0;
      end
    end
  end

  assign full = (cnt_r == (AW+1)'(DEPTH));
  assign empty = (cnt_r == '0);
  assign head = q_r[rp_r];

  always_ff @(posedge clk) begin
    if (push && !full) q_r[wp_r] <= masked;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      if (push && !full) wp_r <= (wp_r == AW'(DEPTH-1)) ? '0 : wp_r + 1'b1;
      if (pop && !empty) rp_r <= (rp_r == AW'(DEPTH-1)) ? '0 : rp_r + 1'b1;
      cnt_r <= cnt_r + (AW+1)'(push && !full) - (AW+1)'(pop && !empty);
    end
  end

  `ASSERT_IMPL(a_full_holds, clk, rst_n, (full && !pop) |=> full)
  `ASSERT_NEVER(a_no_underflow, clk, rst_n, pop && empty)
  `ASSERT_IMPL(a_cnt_range, clk, rst_n, cnt_r <= (AW+1)'(DEPTH))
endmodule

// File: src/bti_back.sv
// Walk engine: searches and inserts over the node memory.
// Depends on bti_pkg and assert_macros.svh.
`include "assert_macros.svh"
module bti_back #(
  parameter int KEY_BITS = 32,
  parameter int MAX_KEYS = 256
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               empty,
  input  bti_pkg::in_item_t  head,
  output logic               pop,
  output logic               idle,
  output logic               out_valid,
  output bti_pkg::out_item_t out_item
);
  localparam int SLOTS = 2 * MAX_KEYS;
  localparam int IW = $clog2(SLOTS);
  localparam int PW = (KEY_BITS > 1) ? $clog2(KEY_BITS) : 1;

  typedef struct packed {
    logic               leaf;
    logic [KEY_BITS-1:0] key;
    logic [PW-1:0]      pos;
    logic [IW-1:0]      left;
    logic [IW-1:0]      right;
  } node_t;

  node_t mem [SLOTS];
  node_t rd_r;

  logic [IW-1:0] root_r, root_nxt;
  logic          rootv_r, rootv_nxt;
  logic [IW:0]   free_r, free_nxt;
  bti_pkg::back_state_t st_r, st_nxt;
  logic          ins_r, ins_nxt;
  logic [KEY_BITS-1:0] key_r, key_nxt;
  logic [IW-1:0] cur_r, cur_nxt, par_r, par_nxt;
  logic          hasp_r, hasp_nxt, right_r, right_nxt;
  logic [KEY_BITS-1:0] okey_r, okey_nxt;
  logic [PW-1:0] dpos_r, dpos_nxt;
  logic          ovalid_r, ovalid_nxt;
  bti_pkg::out_item_t oitem_r, oitem_nxt;

  logic          we, re;
  logic [IW-1:0] waddr, raddr;
  node_t         wdata;

  logic [KEY_BITS-1:0] diff;
  logic          bit_sel;
  logic [IW:0]   need;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rd_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= bti_pkg::BK_IDLE;
      root_r <= '0;
      rootv_r <= 1'b0;
      free_r <= '0;
      ovalid_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      root_r <= root_nxt;
      rootv_r <= rootv_nxt;
      free_r <= free_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ins_r <= ins_nxt;
    key_r <= key_nxt;
    cur_r <= cur_nxt;
    par_r <= par_nxt;
    hasp_r <= hasp_nxt;
    right_r <= right_nxt;
    okey_r <= okey_nxt;
    dpos_r <= dpos_nxt;
    oitem_r <= oitem_nxt;
  end

  assign diff = okey_r ^ key_r;
  assign bit_sel = key_r[KEY_BITS-1-32'(rd_r.pos)];

  always_comb begin
    st_nxt = st_r;
    root_nxt = root_r;
    rootv_nxt = rootv_r;
    free_nxt = free_r;
    ins_nxt = ins_r;
    key_nxt = key_r;
    cur_nxt = cur_r;
    par_nxt = par_r;
    hasp_nxt = hasp_r;
    right_nxt = right_r;
    okey_nxt = okey_r;
    dpos_nxt = dpos_r;
    ovalid_nxt = 1'b0;
    oitem_nxt = oitem_r;
    pop = 1'b0;
    we = 1'b0;
    re = 1'b0;
    waddr = '0;
    raddr = cur_r;
    wdata = '0;
    need = rootv_r ? (IW+1)'(2) : (IW+1)'(1);
    case (st_r)
      bti_pkg::BK_IDLE: begin
        if (!empty) begin
          pop = 1'b1;
          ins_nxt = head.command;
          key_nxt = KEY_BITS'(head.key);
          cur_nxt = root_r;
          hasp_nxt = 1'b0;
          if (!rootv_r) begin
            ovalid_nxt = 1'b1;
            oitem_nxt = '{status: bti_pkg::ST_MISSING, leaf_index: '0};
            if (head.command == bti_pkg::CMD_INSERT) begin
              if (free_r + need > (IW+1)'(SLOTS)) begin
                oitem_nxt.status = bti_pkg::ST_FULL;
              end else begin
                we = 1'b1;
                waddr = free_r[IW-1:0];
                wdata.leaf = 1'b1;
                wdata.key = KEY_BITS'(head.key);
                root_nxt = free_r[IW-1:0];
                rootv_nxt = 1'b1;
                free_nxt = free_r + 1'b1;
                oitem_nxt.status = bti_pkg::ST_INSERTED;
                oitem_nxt.leaf_index = 9'(free_r[IW-1:0]);
              end
            end
          end else begin
            st_nxt = bti_pkg::BK_READ;
          end
        end
      end
      bti_pkg::BK_READ: begin
        re = 1'b1;
        st_nxt = bti_pkg::BK_WAIT;
      end
      bti_pkg::BK_WAIT: begin
        st_nxt = bti_pkg::BK_STEP;
      end
      bti_pkg::BK_STEP: begin
        if (!rd_r.leaf) begin
          par_nxt = cur_r;
          hasp_nxt = 1'b1;
          right_nxt = bit_sel;
          cur_nxt = bit_sel ? rd_r.right : rd_r.left;
          st_nxt = bti_pkg::BK_READ;
        end else if (rd_r.key == key_r) begin
          ovalid_nxt = 1'b1;
          oitem_nxt = '{status: bti_pkg::ST_FOUND, leaf_index: 9'(cur_r)};
          st_nxt = bti_pkg::BK_IDLE;
        end else if (ins_r != bti_pkg::CMD_INSERT) begin
          ovalid_nxt = 1'b1;
          oitem_nxt = '{status: bti_pkg::ST_MISSING, leaf_index: '0};
          st_nxt = bti_pkg::BK_IDLE;
        end else if (free_r + need > (IW+1)'(SLOTS)) begin
          ovalid_nxt = 1'b1;
          oitem_nxt = '{status: bti_pkg::ST_FULL, leaf_index: '0};
          st_nxt = bti_pkg::BK_IDLE;
        end else begin
          okey_nxt = rd_r.key;
          st_nxt = bti_pkg::BK_DIFF;
        end
      end
      bti_pkg::BK_DIFF: begin
        // Priority encoder for the first differing bit, MSB first.
        dpos_nxt = '0;
        for (int p = KEY_BITS - 1; p >= 0; p--) begin
          if (diff[KEY_BITS-1-p]) dpos_nxt = PW'(p);
        end
        st_nxt = bti_pkg::BK_WRITE;
      end
      bti_pkg::BK_WRITE: begin
        we = 1'b1;
        waddr = free_r[IW-1:0] + 1'b1;
        wdata.leaf = 1'b1;
        wdata.key = key_r;
        st_nxt = bti_pkg::BK_LINK;
      end
      bti_pkg::BK_LINK: begin
        we = 1'b1;
        waddr = free_r[IW-1:0];
        wdata.pos = dpos_r;
        if (okey_r[KEY_BITS-1-32'(dpos_r)]) begin
          wdata.left = free_r[IW-1:0] + 1'b1;
          wdata.right = cur_r;
        end else begin
          wdata.left = cur_r;
          wdata.right = free_r[IW-1:0] + 1'b1;
        end
        if (!hasp_r) root_nxt = free_r[IW-1:0];
        st_nxt = hasp_r ? bti_pkg::BK_DONE : bti_pkg::BK_IDLE;
        if (!hasp_r) begin
          ovalid_nxt = 1'b1;
          oitem_nxt = '{status: bti_pkg::ST_INSERTED,
                        leaf_index: 9'(free_r[IW-1:0] + 1'b1)};
          free_nxt = free_r + 2'd2;
        end
        // Parent relink needs the parent's other fields: reread it.
        re = hasp_r;
        raddr = par_r;
      end
      bti_pkg::BK_DONE: begin
        if (!we) begin
          we = 1'b1;
          waddr = par_r;
          wdata = rd_r;
          if (right_r) wdata.right = free_r[IW-1:0];
          else wdata.left = free_r[IW-1:0];
          ovalid_nxt = 1'b1;
          oitem_nxt = '{status: bti_pkg::ST_INSERTED,
                        leaf_index: 9'(free_r[IW-1:0] + 1'b1)};
          free_nxt = free_r + 2'd2;
          st_nxt = bti_pkg::BK_IDLE;
        end
      end
      default: st_nxt = bti_pkg::BK_IDLE;
    endcase
  end

  assign idle = (st_r == bti_pkg::BK_IDLE);
  assign out_valid = ovalid_r;
  assign out_item = oitem_r;

  `ASSERT_IMPL(a_free_bound, clk, rst_n, free_r <= (IW+1)'(SLOTS))
  `ASSERT_IMPL(a_free_grows, clk, rst_n, free_r >= $past(free_r))
  `ASSERT_IMPL(a_pop_idle, clk, rst_n, pop |-> st_r == bti_pkg::BK_IDLE)
  `ASSERT_IMPL(a_root_sticky, clk, rst_n, $past(rootv_r) |-> rootv_r)
endmodule

// File: src/binary_trie_insert_search.sv
// Top level of the binary radix trie search and insert block.
// Depends on bti_pkg, bti_front, bti_back and assert_macros.svh.
//
//  channel  ports                      accept rule
//  input    start, busy, in_item       start && !busy at the edge
//  result   out_valid, out_item        strobe high for one cycle
//
// An item first leaves the queue, then each node read passes through memory
// read, registered read data, and branch or leaf decision; an insert that
// splits a leaf adds first difference, leaf write and inner node write,
// plus a parent relink. A 32-bit key reads at most 33 nodes. The result is
// registered and strobes in the cycle after the engine decides it. Node
// reads go one at a time, and the engine takes no new item until the last
// is through. Reset (synchronous, active low) empties the trie; node memory
// is not cleared. The receiver cannot stall: results are strobed and dropped
// if ignored. busy rises when the two-entry queue fills.
`include "assert_macros.svh"
module binary_trie_insert_search #(
  parameter int KEY_BITS = 32,
  parameter int MAX_KEYS = 256
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  bti_pkg::in_item_t  in_item,
  output logic               out_valid,
  output bti_pkg::out_item_t out_item
);
  logic              q_full, q_empty, q_pop, bk_idle;
  bti_pkg::in_item_t q_head;

  // Busy while the queue is full; the walk engine drains it item by item.
  assign busy = q_full;

  bti_front #(.KEY_BITS(KEY_BITS), .DEPTH(2)) u_front (
    .clk(clk), .rst_n(rst_n),
    .push(start), .push_item(in_item),
    .full(q_full), .empty(q_empty),
    .pop(q_pop), .head(q_head)
  );

  bti_back #(.KEY_BITS(KEY_BITS), .MAX_KEYS(MAX_KEYS)) u_back (
    .clk(clk), .rst_n(rst_n),
    .empty(q_empty), .head(q_head), .pop(q_pop), .idle(bk_idle),
    .out_valid(out_valid), .out_item(out_item)
  );

  // The engine only takes a new item from the queue when it is idle.
  `ASSERT_IMPL(a_pop_when_idle, clk, rst_n, q_pop |-> bk_idle)
  // A full queue is never empty at the same time.
  `ASSERT_NEVER(a_busy_not_empty, clk, rst_n, busy && q_empty)
  // Every strobed result carries defined fields.
  `ASSERT_IMPL(a_out_known, clk, rst_n, out_valid |-> !$isunknown(out_item))
endmodule
